// ----- rtl/core/ascr_pkg.sv -----
// Package for the adaptive sine current reference.
// Holds command, phase and register codes, reset values, and the half-sine table.
// No dependencies.
`default_nettype none

package ascr_pkg;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned DUTY_W   = 16;
   localparam int unsigned AMP_W    = 16;
   localparam int unsigned POS_W    = 8;
   localparam int unsigned LEAD_W   = 3;
   localparam int unsigned ROM_W    = 12;
   localparam int unsigned ROM_SIZE = 256;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 12;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [DUTY_W-1:0]   duty_type;
   typedef logic [AMP_W-1:0]    amp_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [LEAD_W-1:0]   lead_type;
   typedef logic [ROM_W-1:0]    rom_word_type;
   typedef logic [1:0]          phase_type;

   // operands handed to the duty multiplier
   typedef struct packed {
      pos_type  position;
      lead_type lead;
      amp_type  amplitude;
   } duty_req_type;

   localparam cmd_type CMD_SAMPLE  = 2'd0;
   localparam cmd_type CMD_START   = 2'd1;
   localparam cmd_type CMD_RESTART = 2'd2;
   localparam cmd_type CMD_UNUSED  = 2'd3;

   localparam phase_type PH_RISING  = 2'd0;
   localparam phase_type PH_MIDDLE  = 2'd1;
   localparam phase_type PH_FALLING = 2'd2;
   localparam phase_type PH_REVERT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_PEAK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_END    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_END  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CUT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LEAD    = 3'd5;

   localparam sample_type RST_TARGET_PEAK = 12'd0;
   localparam pos_type    RST_RISE_END    = 8'd115;
   localparam pos_type    RST_MIDDLE_END  = 8'd123;
   localparam pos_type    RST_CUT         = 8'd210;
   localparam pos_type    RST_CENTRE      = 8'd119;
   localparam lead_type   RST_MAX_LEAD    = 3'd5;

   localparam rom_word_type SINE_ROM [ROM_SIZE] = '{
      12'd53,   12'd107,  12'd160,  12'd214,  12'd267,  12'd321,  12'd374,  12'd428,
      12'd481,  12'd534,  12'd587,  12'd640,  12'd693,  12'd746,  12'd798,  12'd851,
      12'd903,  12'd955,  12'd1007, 12'd1059, 12'd1111, 12'd1163, 12'd1214, 12'd1265,
      12'd1316, 12'd1366, 12'd1417, 12'd1467, 12'd1517, 12'd1567, 12'd1616, 12'd1665,
      12'd1714, 12'd1762, 12'd1811, 12'd1859, 12'd1906, 12'd1953, 12'd2000, 12'd2047,
      12'd2093, 12'd2139, 12'd2185, 12'd2230, 12'd2275, 12'd2319, 12'd2363, 12'd2406,
      12'd2450, 12'd2492, 12'd2535, 12'd2577, 12'd2618, 12'd2659, 12'd2700, 12'd2740,
      12'd2779, 12'd2818, 12'd2857, 12'd2895, 12'd2933, 12'd2970, 12'd3007, 12'd3043,
      12'd3078, 12'd3113, 12'd3148, 12'd3182, 12'd3215, 12'd3248, 12'd3281, 12'd3312,
      12'd3344, 12'd3374, 12'd3404, 12'd3434, 12'd3463, 12'd3491, 12'd3519, 12'd3546,
      12'd3572, 12'd3598, 12'd3624, 12'd3648, 12'd3672, 12'd3696, 12'd3718, 12'd3740,
      12'd3762, 12'd3783, 12'd3803, 12'd3823, 12'd3841, 12'd3860, 12'd3877, 12'd3894,
      12'd3910, 12'd3926, 12'd3941, 12'd3955, 12'd3969, 12'd3981, 12'd3994, 12'd4005,
      12'd4016, 12'd4026, 12'd4035, 12'd4044, 12'd4052, 12'd4059, 12'd4066, 12'd4072,
      12'd4077, 12'd4082, 12'd4086, 12'd4089, 12'd4091, 12'd4093, 12'd4094, 12'd4095,
      12'd4094, 12'd4093, 12'd4091, 12'd4089, 12'd4086, 12'd4082, 12'd4077, 12'd4072,
      12'd4066, 12'd4059, 12'd4052, 12'd4044, 12'd4035, 12'd4026, 12'd4016, 12'd4005,
      12'd3994, 12'd3981, 12'd3969, 12'd3955, 12'd3941, 12'd3926, 12'd3910, 12'd3894,
      12'd3877, 12'd3860, 12'd3841, 12'd3823, 12'd3803, 12'd3783, 12'd3762, 12'd3740,
      12'd3718, 12'd3696, 12'd3672, 12'd3648, 12'd3624, 12'd3598, 12'd3572, 12'd3546,
      12'd3519, 12'd3491, 12'd3463, 12'd3434, 12'd3404, 12'd3374, 12'd3344, 12'd3312,
      12'd3281, 12'd3248, 12'd3215, 12'd3182, 12'd3148, 12'd3113, 12'd3078, 12'd3043,
      12'd3007, 12'd2970, 12'd2933, 12'd2895, 12'd2857, 12'd2818, 12'd2779, 12'd2740,
      12'd2700, 12'd2659, 12'd2618, 12'd2577, 12'd2535, 12'd2492, 12'd2450, 12'd2406,
      12'd2363, 12'd2319, 12'd2275, 12'd2230, 12'd2185, 12'd2139, 12'd2093, 12'd2047,
      12'd2000, 12'd1953, 12'd1906, 12'd1859, 12'd1811, 12'd1762, 12'd1714, 12'd1665,
      12'd1616, 12'd1567, 12'd1517, 12'd1467, 12'd1417, 12'd1366, 12'd1316, 12'd1265,
      12'd1214, 12'd1163, 12'd1111, 12'd1059, 12'd1007, 12'd955,  12'd903,  12'd851,
      12'd798,  12'd746,  12'd693,  12'd640,  12'd587,  12'd534,  12'd481,  12'd428,
      12'd374,  12'd321,  12'd267,  12'd214,  12'd160,  12'd107,  12'd53,   12'd0,
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0
   };

endpackage

`default_nettype wire

// ----- rtl/core/ascr_channels_if.sv -----
// Valid/ready channel interfaces for the sine current reference.
// Depends on ascr_pkg for payload types.
`default_nettype none

interface ascr_req_if;
   import ascr_pkg::*;
   logic       valid;
   logic       ready;
   cmd_type    cmd;
   sample_type current_sample;
   modport source (output valid, output cmd, output current_sample, input ready);
   modport sink   (input valid, input cmd, input current_sample, output ready);
endinterface

interface ascr_rsp_if;
   import ascr_pkg::*;
   logic     valid;
   logic     ready;
   logic     finished;
   logic     duty_valid;
   duty_type duty;
   modport source (output valid, output finished, output duty_valid, output duty,
                   input ready);
   modport sink   (input valid, input finished, input duty_valid, input duty,
                   output ready);
endinterface

interface ascr_csr_if;
   import ascr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ascr_duty_calc.sv -----
// Duty datapath: lead-shifted half-sine lookup times amplitude, scaled by 1/4096.
// Depends on ascr_pkg for the table and operand struct.
`default_nettype none

module ascr_duty_calc
   import ascr_pkg::*;
#(
   parameter int unsigned TABLE_SIZE = 240
) (
   input  duty_req_type op,
   output duty_type     duty
);

   localparam logic [POS_W:0] LAST_POS = (POS_W+1)'(TABLE_SIZE - 1);
   localparam logic [POS_W:0] TBL_END  = (POS_W+1)'(TABLE_SIZE);

   logic [POS_W:0]            lead_idx;
   pos_type                   rom_addr;
   rom_word_type              rom_word;
   logic [ROM_W+AMP_W-1:0]    prod;

   always_comb begin
      lead_idx = {1'b0, op.position} + {{(POS_W+1-LEAD_W){1'b0}}, op.lead};
      // lead reaches the last table entry or runs past it: fall back to the unshifted entry
      if (lead_idx >= LAST_POS) begin
         rom_addr = op.position;
      end else begin
         rom_addr = lead_idx[POS_W-1:0];
      end
      if ({1'b0, rom_addr} >= TBL_END) begin
         rom_word = '0;
      end else begin
         rom_word = SINE_ROM[rom_addr];
      end
      prod = {{AMP_W{1'b0}}, rom_word} * {{ROM_W{1'b0}}, op.amplitude};
   end

   assign duty = prod[ROM_W+DUTY_W-1:ROM_W];

endmodule

`default_nettype wire

// ----- rtl/core/adaptive_sine_current_reference_top.sv -----
// Top level of the adaptive sine current reference: half-cycle sequencer,
// peak tracking, amplitude/lead correction and result register.
// Depends on ascr_pkg, ascr_channels_if and ascr_duty_calc.
//
//  channel  dir  payload                          beat when
//  req_bus  in   cmd, current_sample              valid && ready
//  rsp_bus  out  finished, duty_valid, duty       valid && ready
//  csr_bus  in   index, data (12b, low bits used) valid (ready tied high)
//
// One beat per cycle while req ready is high; a sample step's result appears in the cycle after its beat.
// Each sample step does a single combinational ROM lookup and 12x16 multiply.
// Start and restart commands update state, unused commands do nothing, and none produce a result.
// req ready drops only while a result is held and rsp ready is low.
// Synchronous active-high reset restores register defaults and clears state.
`default_nettype none

module adaptive_sine_current_reference_top
   import ascr_pkg::*;
#(
   parameter int unsigned TABLE_SIZE = 240
) (
   input  wire         clock,
   input  wire         reset,
   ascr_req_if.sink    req_bus,
   ascr_rsp_if.source  rsp_bus,
   ascr_csr_if.sink    csr_bus
);

   localparam logic [POS_W:0] LAST_POS = (POS_W+1)'(TABLE_SIZE - 1);

   // configuration
   sample_type target_peak_ff;
   pos_type    rise_end_ff, middle_end_ff, cut_ff, centre_ff;
   lead_type   max_lead_ff;

   // half-cycle state
   pos_type    position_ff, position_in;
   phase_type  phase_ff, phase_in;
   sample_type meas_peak_ff, meas_peak_in;
   pos_type    peak_pos_ff, peak_pos_in;
   amp_type    amplitude_ff, amplitude_in;
   lead_type   lead_ff, lead_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       finished_ff, finished_in;
   logic       duty_valid_ff, duty_valid_in;
   duty_type   duty_ff, duty_in;

   logic         req_beat;
   logic         rsp_load;
   amp_type      amp_eff;
   sample_type   meas_eff;
   pos_type      peak_pos_eff;
   duty_req_type duty_op;
   duty_type     duty_raw;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign amp_eff = (amplitude_ff == '0) ?
                    {{(AMP_W-SAMPLE_W+3){1'b0}}, target_peak_ff[SAMPLE_W-1:3]} :
                    amplitude_ff;

   assign duty_op = '{position: position_ff, lead: lead_ff, amplitude: amp_eff};

   ascr_duty_calc #(.TABLE_SIZE(TABLE_SIZE)) u_duty_calc (
      .op   (duty_op),
      .duty (duty_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         target_peak_ff <= RST_TARGET_PEAK;
         rise_end_ff    <= RST_RISE_END;
         middle_end_ff  <= RST_MIDDLE_END;
         cut_ff         <= RST_CUT;
         centre_ff      <= RST_CENTRE;
         max_lead_ff    <= RST_MAX_LEAD;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_TARGET_PEAK: target_peak_ff <= csr_bus.data[SAMPLE_W-1:0];
            REG_RISE_END:    rise_end_ff    <= csr_bus.data[POS_W-1:0];
            REG_MIDDLE_END:  middle_end_ff  <= csr_bus.data[POS_W-1:0];
            REG_CUT:         cut_ff         <= csr_bus.data[POS_W-1:0];
            REG_CENTRE:      centre_ff      <= csr_bus.data[POS_W-1:0];
            REG_MAX_LEAD:    max_lead_ff    <= csr_bus.data[LEAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      position_in   = position_ff;
      phase_in      = phase_ff;
      meas_peak_in  = meas_peak_ff;
      peak_pos_in   = peak_pos_ff;
      amplitude_in  = amplitude_ff;
      lead_in       = lead_ff;
      rsp_load      = 1'b0;
      finished_in   = finished_ff;
      duty_valid_in = duty_valid_ff;
      duty_in       = duty_ff;
      meas_eff      = (meas_peak_ff < req_bus.current_sample) ?
                      req_bus.current_sample : meas_peak_ff;
      peak_pos_eff  = (meas_peak_ff < req_bus.current_sample) ? position_ff : peak_pos_ff;

      if (req_beat) begin
         unique case (req_bus.cmd)
            CMD_START: begin
               position_in  = '0;
               phase_in     = PH_RISING;
               meas_peak_in = '0;
               peak_pos_in  = '0;
            end
            CMD_RESTART: begin
               position_in  = '0;
               phase_in     = PH_RISING;
               meas_peak_in = '0;
               peak_pos_in  = '0;
               amplitude_in = '0;
               lead_in      = '0;
            end
            CMD_SAMPLE: begin
               rsp_load = 1'b1;
               if ({1'b0, position_ff} >= LAST_POS) begin
                  // table exhausted: report and hold everything
                  finished_in   = 1'b1;
                  duty_valid_in = 1'b0;
                  duty_in       = '0;
               end else begin
                  finished_in   = 1'b0;
                  duty_valid_in = 1'b1;
                  duty_in       = duty_raw;
                  amplitude_in  = amp_eff;
                  position_in   = position_ff + POS_W'(1);
                  if (phase_ff == PH_REVERT) begin
                     duty_valid_in = 1'b0;
                     duty_in       = '0;
                  end else begin
                     meas_peak_in = meas_eff;
                     peak_pos_in  = peak_pos_eff;
                     if (phase_ff == PH_RISING) begin
                        if (position_ff > rise_end_ff) phase_in = PH_MIDDLE;
                     end else if (phase_ff == PH_MIDDLE) begin
                        if (position_ff > middle_end_ff) phase_in = PH_FALLING;
                     end else if (position_ff > cut_ff) begin
                        if (meas_eff < target_peak_ff) begin
                           if (amp_eff != '1) amplitude_in = amp_eff + AMP_W'(1);
                        end else if (meas_eff > target_peak_ff) begin
                           if (amp_eff != '0) amplitude_in = amp_eff - AMP_W'(1);
                        end
                        if (peak_pos_eff > centre_ff) begin
                           if (lead_ff < max_lead_ff) lead_in = lead_ff + LEAD_W'(1);
                        end else if (peak_pos_eff < centre_ff) begin
                           if (lead_ff != '0) lead_in = lead_ff - LEAD_W'(1);
                        end
                        phase_in = PH_REVERT;
                        duty_in  = '0;
                     end
                  end
               end
            end
            CMD_UNUSED: ;
            default: ;
         endcase
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         phase_ff     <= PH_RISING;
         meas_peak_ff <= '0;
         peak_pos_ff  <= '0;
         amplitude_ff <= '0;
         lead_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         phase_ff     <= phase_in;
         meas_peak_ff <= meas_peak_in;
         peak_pos_ff  <= peak_pos_in;
         amplitude_ff <= amplitude_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         finished_ff   <= finished_in;
         duty_valid_ff <= duty_valid_in;
         duty_ff       <= duty_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.finished   = finished_ff;
   assign rsp_bus.duty_valid = duty_valid_ff;
   assign rsp_bus.duty       = duty_ff;

   a_finished_no_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.finished |-> !rsp_bus.duty_valid && rsp_bus.duty == '0)
      else $error("finished beat carries a duty");

   a_no_duty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.duty_valid |-> rsp_bus.duty == '0)
      else $error("unwritten duty is not zero");

   a_step_advances: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_bus.cmd == CMD_SAMPLE && {1'b0, position_ff} < LAST_POS
      |=> position_ff == $past(position_ff) + POS_W'(1) && rsp_valid_ff)
      else $error("sample step did not advance position or load a result");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_bus.cmd == CMD_START || req_bus.cmd == CMD_RESTART)
      |=> position_ff == '0 && phase_ff == PH_RISING && meas_peak_ff == '0)
      else $error("start did not clear the half cycle");

   a_restart_clears_amp: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_bus.cmd == CMD_RESTART |=> amplitude_ff == '0 && lead_ff == '0)
      else $error("restart did not clear amplitude and lead");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for adaptive_sine_current_reference_top.
// Needs ascr_pkg, the ascr_*_if channel interfaces and the block's RTL;
// a directed table runs first, then random half-cycles against a local predictor.
`timescale 1ns / 100ps

module tb_top;
   import ascr_pkg::*;

   localparam int unsigned TABLE_SIZE       = 240;
   localparam int unsigned RANDOM_ITEMS     = 1000;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT      = 500000;
   localparam int unsigned REPORT_LIMIT     = 10;

   typedef struct packed {
      logic     finished;
      logic     duty_valid;
      duty_type duty;
   } duty_beat_t;

   typedef struct packed {
      sample_type target;
      pos_type    rise;
      pos_type    mid;
      pos_type    cut;
      pos_type    centre;
      lead_type   max_lead;
   } settings_t;

   typedef struct packed {
      cmd_type    cmd;
      sample_type sample;
      logic       typed;
      logic       reconfig;
      duty_beat_t beat;
   } plan_row_t;

   localparam duty_beat_t ZERO_DUTY   = '{1'b0, 1'b1, 16'd0};
   localparam duty_beat_t REVERT_BEAT = '{1'b0, 1'b0, 16'd0};
   localparam duty_beat_t NO_BEAT     = '0;
   localparam settings_t  DIRECTED_SETTINGS = '{12'd4095, 8'd0, 8'd1, 8'd3, 8'd0, 3'd7};

   logic clock = 1'b0;
   logic reset;

   ascr_req_if req_bus ();
   ascr_rsp_if rsp_bus ();
   ascr_csr_if csr_bus ();

   adaptive_sine_current_reference_top #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // predictor state
   settings_t  cfg;
   pos_type    track_pos;
   phase_type  track_phase;
   sample_type track_peak;
   pos_type    track_peak_pos;
   amp_type    track_amp;
   lead_type   track_lead;

   duty_beat_t  pending_duty [$];
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   int unsigned random_items;
   logic        hold_armed;
   logic        hold_done;
   duty_beat_t  seen_beat;
   duty_beat_t  want_beat;

   task automatic restart_half_cycle();
      track_peak     = '0;
      track_peak_pos = '0;
      track_pos      = '0;
      track_phase    = PH_RISING;
   endtask

   task automatic reset_predictor();
      cfg = '{RST_TARGET_PEAK, RST_RISE_END, RST_MIDDLE_END, RST_CUT, RST_CENTRE,
              RST_MAX_LEAD};
      track_amp  = '0;
      track_lead = '0;
      restart_half_cycle();
   endtask

   task automatic predict_duty_beat(input cmd_type c, input sample_type s,
                                    output logic has_beat, output duty_beat_t beat);
      int unsigned slot;
      logic [31:0] prod;
      has_beat = 1'b0;
      beat     = NO_BEAT;
      case (c)
         CMD_START: begin
            restart_half_cycle();
         end
         CMD_RESTART: begin
            track_amp  = '0;
            track_lead = '0;
            restart_half_cycle();
         end
         CMD_SAMPLE: begin
            has_beat = 1'b1;
            if (32'(track_pos) >= TABLE_SIZE - 1) begin
               beat = '{1'b1, 1'b0, 16'd0};
            end else begin
               if (track_amp == '0) track_amp = amp_type'(cfg.target >> 3);
               slot = 32'(track_pos) + 32'(track_lead);
               // lead would reach the last table entry or run off the end: use the plain position
               if (slot >= TABLE_SIZE - 1) slot = 32'(track_pos);
               prod = 32'(SINE_ROM[slot[7:0]]) * 32'(track_amp);
               beat = '{1'b0, 1'b1, prod[27:12]};
               if (track_phase == PH_REVERT) begin
                  beat = REVERT_BEAT;
               end else begin
                  if (track_peak < s) begin
                     track_peak     = s;
                     track_peak_pos = track_pos;
                  end
                  if (track_phase == PH_RISING) begin
                     if (track_pos > cfg.rise) track_phase = PH_MIDDLE;
                  end else if (track_phase == PH_MIDDLE) begin
                     if (track_pos > cfg.mid) track_phase = PH_FALLING;
                  end else if (track_pos > cfg.cut) begin
                     if (track_peak < cfg.target) begin
                        if (track_amp != 16'hFFFF) track_amp = track_amp + 16'd1;
                     end else if (track_peak > cfg.target) begin
                        if (track_amp != '0) track_amp = track_amp - 16'd1;
                     end
                     if (track_peak_pos > cfg.centre) begin
                        if (track_lead < cfg.max_lead) track_lead = track_lead + 3'd1;
                     end else if (track_peak_pos < cfg.centre) begin
                        if (track_lead != '0) track_lead = track_lead - 3'd1;
                     end
                     track_phase = PH_REVERT;
                     beat.duty   = '0;
                  end
               end
               track_pos = track_pos + 8'd1;
            end
         end
         default: ;
      endcase
   endtask

   // one request beat; bursts and gaps are handled here
   task automatic offer(input cmd_type c, input sample_type s, input logic typed,
                        input duty_beat_t typed_beat);
      int unsigned gap;
      logic        has_beat;
      duty_beat_t  beat;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_bus.valid          <= 1'b1;
      req_bus.cmd            <= c;
      req_bus.current_sample <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_duty_beat(c, s, has_beat, beat);
      if (has_beat) pending_duty.push_back(typed ? typed_beat : beat);
   endtask

   task automatic finish_outstanding();
      req_bus.valid <= 1'b0;
      while (pending_duty.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic load_settings(input settings_t s);
      write_reg(REG_TARGET_PEAK, s.target);
      write_reg(REG_RISE_END, CSR_DATA_W'(s.rise));
      write_reg(REG_MIDDLE_END, CSR_DATA_W'(s.mid));
      write_reg(REG_CUT, CSR_DATA_W'(s.cut));
      write_reg(REG_CENTRE, CSR_DATA_W'(s.centre));
      write_reg(REG_MAX_LEAD, CSR_DATA_W'(s.max_lead));
      csr_bus.valid <= 1'b0;
      cfg = s;
   endtask

   function automatic settings_t pick_settings(input int unsigned phase_no);
      settings_t s;
      if (phase_no == 0) begin
         s = '{12'd4095, 8'd239, 8'd239, 8'd239, 8'd239, 3'd7};
      end else if (phase_no == 1) begin
         s = '0;
      end else begin
         s.target   = sample_type'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 4095));
         s.rise     = pos_type'($urandom_range(0, 120));
         s.mid      = pos_type'(32'(s.rise) + $urandom_range(0, 60));
         s.cut      = pos_type'(32'(s.mid) + $urandom_range(0, 239 - 32'(s.mid)));
         // occasionally an out-of-order phase layout
         if ($urandom_range(0, 3) == 0) begin
            s.rise = pos_type'($urandom_range(0, 239));
            s.mid  = pos_type'($urandom_range(0, 239));
            s.cut  = pos_type'($urandom_range(0, 239));
         end
         s.centre   = pos_type'($urandom_range(0, 239));
         s.max_lead = lead_type'($urandom_range(0, 7));
      end
      return s;
   endfunction

   // start or restart command, then sample steps; a full run can reach table exhaustion
   task automatic run_half_cycle();
      int unsigned steps;
      int unsigned ceiling;
      cmd_type     opener;
      opener = ($urandom_range(0, 3) == 0) ? CMD_RESTART : CMD_START;
      offer(opener, sample_type'($urandom_range(0, 4095)), 1'b0, NO_BEAT);
      random_items++;
      case ($urandom_range(0, 2))
         0:       steps = 240 + $urandom_range(0, 4);
         1:       steps = 32'(cfg.cut) + 2 + $urandom_range(0, 5);
         default: steps = $urandom_range(1, 60);
      endcase
      ceiling = ($urandom_range(0, 1) == 0) ? 4095 : $urandom_range(0, 4095);
      for (int unsigned k = 0; k < steps; k++) begin
         if ($urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               offer(CMD_UNUSED, sample_type'($urandom_range(0, 4095)), 1'b0, NO_BEAT);
            end else begin
               offer(CMD_START, sample_type'($urandom_range(0, 4095)), 1'b0, NO_BEAT);
               random_items++;
            end
         end
         offer(CMD_SAMPLE, sample_type'($urandom_range(0, ceiling)), 1'b0, NO_BEAT);
         random_items++;
      end
   endtask

   task automatic report_error(input string what, input duty_beat_t want,
                               input duty_beat_t got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t %s: expected fin=%0d dv=%0d duty=%0d, got fin=%0d dv=%0d duty=%0d",
                  $realtime, what, want.finished, want.duty_valid, want.duty,
                  got.finished, got.duty_valid, got.duty);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_beat = '{rsp_bus.finished, rsp_bus.duty_valid, rsp_bus.duty};
         if (pending_duty.size() == 0) begin
            report_error("unexpected duty beat", NO_BEAT, seen_beat);
         end else begin
            want_beat = pending_duty.pop_front();
            if (seen_beat !== want_beat) report_error("duty beat mismatch", want_beat, seen_beat);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: stall pattern is redrawn at random from four kinds; one long hold when armed
   initial begin : rsp_side
      logic [15:0] stall_pat;
      int unsigned tick;
      tick      = 0;
      stall_pat = '1;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (tick % 64 == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pat = '1;
               1:       stall_pat = 16'($urandom);
               2:       stall_pat = 16'($urandom) | 16'($urandom);
               default: stall_pat = 16'($urandom) & 16'($urandom);
            endcase
         end
         rsp_bus.ready <= stall_pat[tick % 16];
         tick++;
      end
   end

   initial begin : stimulus
      plan_row_t   plan [17];
      int unsigned phase_no;
      int unsigned halves;
      plan = '{
         '{CMD_SAMPLE,  12'd0,    1'b1, 1'b0, ZERO_DUTY},   // amplitude still zero
         '{CMD_SAMPLE,  12'd4095, 1'b1, 1'b0, ZERO_DUTY},
         '{CMD_UNUSED,  12'd4095, 1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd2048, 1'b1, 1'b0, ZERO_DUTY},
         '{CMD_START,   12'd0,    1'b0, 1'b0, NO_BEAT},
         '{CMD_RESTART, 12'd0,    1'b0, 1'b1, NO_BEAT},     // first amplitude = target/8
         '{CMD_SAMPLE,  12'd100,  1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd200,  1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd300,  1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd4000, 1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd0,    1'b1, 1'b0, ZERO_DUTY},   // past cut: corrections
         '{CMD_SAMPLE,  12'd4095, 1'b1, 1'b0, REVERT_BEAT},
         '{CMD_UNUSED,  12'd0,    1'b0, 1'b0, NO_BEAT},
         '{CMD_START,   12'd0,    1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd4095, 1'b0, 1'b0, NO_BEAT},     // now with lead 1
         '{CMD_RESTART, 12'd0,    1'b0, 1'b0, NO_BEAT},
         '{CMD_SAMPLE,  12'd1,    1'b0, 1'b0, NO_BEAT}
      };
      error_count  = 0;
      cycle_count  = 0;
      burst_left   = 0;
      random_items = 0;
      hold_armed   = 1'b0;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.cmd            <= CMD_SAMPLE;
      req_bus.current_sample <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= REG_TARGET_PEAK;
      csr_bus.data           <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      reset_predictor();
      @(posedge clock);

      for (int r = 0; r < 17; r++) begin
         if (plan[r].reconfig) begin
            finish_outstanding();
            load_settings(DIRECTED_SETTINGS);
         end
         offer(plan[r].cmd, plan[r].sample, plan[r].typed, plan[r].beat);
      end

      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         finish_outstanding();
         load_settings(pick_settings(phase_no));
         // keep offering while the receiver holds off, to back up the input
         if (phase_no == 1) hold_armed = 1'b1;
         halves = $urandom_range(1, 3);
         for (int unsigned h = 0; h < halves; h++) run_half_cycle();
         phase_no++;
      end

      finish_outstanding();
      if (error_count == 0 && pending_duty.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
